/* src/epm_pkg.sv */
package epm_pkg;

	localparam int unsigned WORD_W = 64;
	localparam int unsigned POOL_N = 4;
	localparam int unsigned SLOT_W = 2;

	// default queue depths
	localparam int unsigned CMD_DEPTH_DEF = 2;
	localparam int unsigned RES_DEPTH_DEF = 2;

	// rotate amounts of the mix
	localparam int unsigned ROT_A = 13;
	localparam int unsigned ROT_B = 16;
	localparam int unsigned ROT_C = 17;
	localparam int unsigned ROT_D = 21;
	localparam int unsigned ROT_H = 32;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [POOL_N-1:0][WORD_W-1:0] pool_t;

	// command codes on the cmd port
	localparam logic [1:0] CMD_INJECT  = 2'd0;
	localparam logic [1:0] CMD_EXTRACT = 2'd1;
	localparam logic [1:0] CMD_STIR    = 2'd2;

	// square-root fraction constants
	localparam pool_t POOL_INIT = {
		64'hA54FF53A5F1D36F1,
		64'h3C6EF372FE94F82B,
		64'hBB67AE8584CAA73B,
		64'h6A09E667F3BCC908
	};

	typedef enum logic [1:0] {
		OP_INJECT,
		OP_EXTRACT,
		OP_STIR
	} op_t;

	typedef struct packed {
		op_t   op;
		word_t sample;
	} cmd_entry_t;

	// request from the command queue to the mixer
	typedef struct packed {
		logic  valid;
		op_t   op;
		word_t sample;
	} cmd_req_t;

	// mixer status seen by the top level
	typedef struct packed {
		logic  take;
		op_t   op;
		slot_t slot;
	} mix_stat_t;

	function automatic word_t rotl(word_t v, int unsigned n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	function automatic pool_t mix_round(pool_t p);
		word_t w0;
		word_t w1;
		word_t w2;
		word_t w3;
		pool_t r;
		w0 = p[0];
		w1 = p[1];
		w2 = p[2];
		w3 = p[3];
		w0 = w0 + w1;
		w2 = w2 + w3;
		w1 = rotl(w1, ROT_A) ^ w0;
		w3 = rotl(w3, ROT_B) ^ w2;
		w0 = rotl(w0, ROT_H);
		w0 = w0 + w3;
		w2 = w2 + w1;
		w1 = rotl(w1, ROT_C) ^ w0;
		w3 = rotl(w3, ROT_D) ^ w2;
		w0 = rotl(w0, ROT_H);
		r[0] = w0;
		r[1] = w1;
		r[2] = w2;
		r[3] = w3;
		return r;
	endfunction

endpackage

/* src/epm_cmd_queue.sv */
module epm_cmd_queue import epm_pkg::*; #(
	parameter int unsigned DEPTH = CMD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  word_t      sample,
	output cmd_req_t   req,
	input  logic       req_ready
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_entry_t             mem_q [DEPTH];
	logic       [PTR_W-1:0] wr_ptr_q;
	logic       [PTR_W-1:0] rd_ptr_q;
	logic       [CNT_W-1:0] count_q;

	logic enq_ok;
	op_t  dec_op;
	logic wr;
	logic rd;

	// classify; the unused code is accepted and dropped
	always_comb begin
		enq_ok = 1'b1;
		dec_op = OP_STIR;
		case (cmd)
			CMD_INJECT: begin
				dec_op = OP_INJECT;
			end
			CMD_EXTRACT: begin
				dec_op = OP_EXTRACT;
			end
			CMD_STIR: begin
				dec_op = OP_STIR;
			end
			default: begin
				enq_ok = 1'b0;
			end
		endcase
	end

	assign full      = (count_q == CNT_W'(DEPTH));
	assign wr        = push && !full && enq_ok;
	assign req.valid = (count_q != '0);
	assign req.op    = mem_q[rd_ptr_q].op;
	assign req.sample = mem_q[rd_ptr_q].sample;
	assign rd        = req.valid && req_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= '{op: dec_op, sample: sample};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/epm_mix_core.sv */
module epm_mix_core import epm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_req_t  req,
	output logic      req_ready,
	input  logic      res_space,
	output logic      res_push,
	output word_t     res_word,
	output mix_stat_t stat
);

	pool_t pool_q;
	slot_t slot_q;

	slot_t slot_nxt;
	pool_t pre;
	pool_t mixed;
	logic  take;

	// extract needs room in the result queue, the others never stall
	assign req_ready = res_space || (req.op != OP_EXTRACT);
	assign take      = req.valid && req_ready;

	always_comb begin
		slot_nxt = slot_q;
		pre      = pool_q;
		case (req.op)
			OP_INJECT: begin
				slot_nxt      = slot_q + 1'b1;
				pre[slot_nxt] = pool_q[slot_nxt] ^ req.sample;
			end
			OP_EXTRACT: begin
				slot_nxt = slot_q + 1'b1;
			end
			default: begin
				slot_nxt = slot_q;
			end
		endcase
		mixed = mix_round(pre);
	end

	assign res_push = take && (req.op == OP_EXTRACT);
	assign res_word = mixed[0] ^ mixed[1] ^ mixed[2] ^ mixed[3];

	assign stat.take = take;
	assign stat.op   = req.op;
	assign stat.slot = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= POOL_INIT;
			slot_q <= '0;
		end else if (take) begin
			pool_q <= mixed;
			slot_q <= slot_nxt;
		end
	end

endmodule

/* src/epm_result_queue.sv */
module epm_result_queue import epm_pkg::*; #(
	parameter int unsigned DEPTH = RES_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  res_push,
	input  word_t res_word,
	output logic  res_space,
	output logic  empty,
	input  logic  pop,
	output word_t random_word
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	word_t             mem_q [DEPTH];
	logic  [PTR_W-1:0] wr_ptr_q;
	logic  [PTR_W-1:0] rd_ptr_q;
	logic  [CNT_W-1:0] count_q;

	logic wr;
	logic rd;

	assign res_space   = (count_q != CNT_W'(DEPTH));
	assign empty       = (count_q == '0);
	assign random_word = mem_q[rd_ptr_q];
	assign wr          = res_push && res_space;
	assign rd          = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= res_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/entropy_pool_mixer_core.sv */
// entropy pool mixer: a 256-bit pool of four 64-bit words and a 2-bit slot
// counter, reset to the square-root fraction constants. each request on the
// push side carries a command: inject (0) xors sample into the word picked by
// the advanced counter and mixes, extract (1) advances the counter, mixes and
// queues the xor of the four words as random_word, stir (2) mixes once, and
// code 3 is accepted and dropped. one request is taken per clock; the mixer
// does a full add-rotate-xor round combinationally, so throughput is one
// request per cycle as long as results are popped. an extract result passes
// through the command queue register, then the mixer, into the result queue
// register before it can be popped. full rises only when the command queue
// holds CMD_DEPTH requests; the mixer holds an extract back while the result
// queue holds RES_DEPTH words. requests are carried out strictly in order.
module entropy_pool_mixer_core import epm_pkg::*; #(
	parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF,  // 2 or more
	parameter int unsigned RES_DEPTH = RES_DEPTH_DEF   // 2 or more
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  word_t      sample,
	output logic       empty,
	input  logic       pop,
	output word_t      random_word
);

	// front: decode and queue requests
	cmd_req_t  req;
	logic      req_ready;

	// back: pool state and mix round
	logic      res_space;
	logic      res_push;
	word_t     res_word;
	mix_stat_t stat;

	epm_cmd_queue #(
		.DEPTH(CMD_DEPTH)
	) u_cmd_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd      (cmd),
		.sample   (sample),
		.req      (req),
		.req_ready(req_ready)
	);

	epm_mix_core u_mix_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_ready(req_ready),
		.res_space(res_space),
		.res_push (res_push),
		.res_word (res_word),
		.stat     (stat)
	);

	// result side: words wait here until popped
	epm_result_queue #(
		.DEPTH(RES_DEPTH)
	) u_result_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_push   (res_push),
		.res_word   (res_word),
		.res_space  (res_space),
		.empty      (empty),
		.pop        (pop),
		.random_word(random_word)
	);

	// a result is never offered to a full result queue
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_space)
		else $error("result pushed into full queue");

	// only an extract produces a result
	a_push_only_extract: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.take && stat.op != OP_EXTRACT) |-> !res_push)
		else $error("result from inject or stir");

	// an extract advances the slot counter by one
	a_extract_steps_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.take && stat.op == OP_EXTRACT) |=> (stat.slot == $past(stat.slot) + 2'd1))
		else $error("slot counter not advanced by extract");

	// a stir leaves the slot counter alone
	a_stir_keeps_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.take && stat.op == OP_STIR) |=> (stat.slot == $past(stat.slot)))
		else $error("slot counter changed by stir");

endmodule
